@@ rtl/core/sbr_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package sbr_pkg;

    localparam int LANES      = 4;
    localparam int LANE_W     = 2;
    localparam int WORD_BITS  = 16;
    localparam int WARP_W     = 3;
    localparam int STACK_LOG2 = 3;
    localparam int CNT_W      = STACK_LOG2 + 1;
    localparam int ROW_W      = WARP_W + STACK_LOG2 - 1;
    localparam int ROWS       = 1 << ROW_W;
    localparam int WARPS      = 1 << WARP_W;
    localparam int LCNT_W     = 3;

    localparam logic [5:0] OP_JMPI  = 6'h1b;
    localparam logic [5:0] OP_JMPR  = 6'h1c;
    localparam logic [5:0] OP_JALI  = 6'h1d;
    localparam logic [5:0] OP_JALR  = 6'h1e;
    localparam logic [5:0] OP_JALIS = 6'h20;
    localparam logic [5:0] OP_JALRS = 6'h21;
    localparam logic [5:0] OP_JMPRT = 6'h22;
    localparam logic [5:0] OP_SPAWN = 6'h3a;
    localparam logic [5:0] OP_SPLIT = 6'h3b;
    localparam logic [5:0] OP_JOIN  = 6'h3c;

    typedef struct packed {
        logic pc_dest;
        logic pc_imm;
        logic mask_lanes;
        logic mask_one;
        logic split;
        logic join_op;
    } sbr_ctrl_t;

    typedef struct packed {
        logic [WARP_W-1:0]    warp_id;
        logic [WORD_BITS-1:0] cur_pc;
        logic [LANES-1:0]     active;
        logic [LANES-1:0]     pred;
        logic                 taken;
        logic [WORD_BITS-1:0] dest_val;
        logic [WORD_BITS-1:0] imm_target;
        logic [LANES-1:0]     lane_mask;
        logic [LANES-1:0]     wb_mask;
        logic [5:0]           wb_reg;
        logic                 spawn;
        logic [WORD_BITS-1:0] spawn_target;
        sbr_ctrl_t            ctrl;
    } sbr_item_t;

    typedef struct packed {
        logic                 ft;
        logic [LANES-1:0]     mask;
        logic [WORD_BITS-1:0] pc;
    } sbr_entry_t;

    typedef struct packed {
        logic [WARP_W-1:0]    warp_id;
        logic [WORD_BITS-1:0] next_pc;
        logic [LANES-1:0]     next_active;
        logic [LANES-1:0]     wb_mask;
        logic [5:0]           wb_reg;
        logic [WORD_BITS-1:0] wb_value;
        logic                 spawn;
        logic [WORD_BITS-1:0] spawn_target;
    } sbr_result_t;

endpackage

`default_nettype wire

@@ rtl/core/sbr_front.sv @@
`timescale 1ns / 1ps
`default_nettype none

module sbr_front
    import sbr_pkg::*;
(
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        push,
    output logic                             full,
    input  wire logic [WARP_W-1:0]           warp_id,
    input  wire logic [WORD_BITS-1:0]        cur_pc,
    input  wire logic [LANES-1:0]            active_mask,
    input  wire logic [LANES-1:0]            pred_mask,
    input  wire logic [5:0]                  opcode,
    input  wire logic signed [WORD_BITS-1:0] immediate,
    input  wire logic                        has_dest,
    input  wire logic [5:0]                  dest_reg,
    input  wire logic [63:0]                 src0_lanes,
    input  wire logic [63:0]                 src1_lanes,
    output logic                             q_valid,
    output sbr_item_t                        q_item,
    input  wire logic                        q_pop
);

    sbr_item_t          item;
    logic [LANES-1:0]   sel;
    logic [LANE_W-1:0]  lane;
    logic [WORD_BITS-1:0] v0;
    logic [WORD_BITS-1:0] v1;
    logic [LCNT_W-1:0]  lanes_val;

    sbr_item_t  q_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] cnt_reg;
    logic [1:0] cnt_next;
    logic       do_push;

    always_comb
    begin
        sel  = active_mask & pred_mask;
        lane = '0;
        for (int i = LANES - 1; i >= 0; i--)
        begin
            if (sel[i])
            begin
                lane = LANE_W'(i);
            end
        end
        v0 = src0_lanes[lane * WORD_BITS +: WORD_BITS];
        v1 = src1_lanes[lane * WORD_BITS +: WORD_BITS];
        lanes_val = opcode[0] ? v1[LCNT_W-1:0] : v0[LCNT_W-1:0];

        item.warp_id    = warp_id;
        item.cur_pc     = cur_pc;
        item.active     = active_mask;
        item.pred       = pred_mask;
        item.taken      = (sel != '0);
        item.dest_val   = (opcode == OP_JALRS) ? v1 : v0;
        item.imm_target = cur_pc + $unsigned(immediate);
        if (lanes_val >= LCNT_W'(LANES))
        begin
            item.lane_mask = '1;
        end
        else
        begin
            item.lane_mask = LANES'((5'd1 << lanes_val) - 5'd1);
        end
        item.wb_mask      = has_dest ? sel : '0;
        item.wb_reg       = dest_reg;
        item.spawn        = (opcode == OP_SPAWN);
        item.spawn_target = v0;

        item.ctrl.pc_dest    = opcode inside {OP_JMPR, OP_JALR, OP_JALRS, OP_JMPRT};
        item.ctrl.pc_imm     = opcode inside {OP_JMPI, OP_JALI, OP_JALIS};
        item.ctrl.mask_lanes = opcode inside {OP_JALIS, OP_JALRS};
        item.ctrl.mask_one   = (opcode == OP_JMPRT);
        item.ctrl.split      = (opcode == OP_SPLIT);
        item.ctrl.join_op    = (opcode == OP_JOIN);
    end

    // two-entry queue toward the back end
    assign full    = (cnt_reg == 2'd2);
    assign q_valid = (cnt_reg != 2'd0);
    assign q_item  = q_reg[rd_ptr_reg];
    assign do_push = push && !full;

    always_comb
    begin
        cnt_next = cnt_reg;
        if (do_push && !q_pop)
        begin
            cnt_next = cnt_reg + 2'd1;
        end
        else if (!do_push && q_pop)
        begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (do_push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (q_pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            q_reg[wr_ptr_reg] <= item;
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/sbr_back.sv @@
`timescale 1ns / 1ps
`default_nettype none

module sbr_back
    import sbr_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       q_valid,
    input  wire sbr_item_t  q_item,
    output logic            q_pop,
    output logic            empty,
    input  wire logic       pop,
    output sbr_result_t     result
);

    // stack split into even and odd slot banks: a split writes one of each while both slots fit
    sbr_entry_t mem_even [ROWS];
    sbr_entry_t mem_odd  [ROWS];
    logic [ROWS-1:0] val_even_reg;
    logic [ROWS-1:0] val_odd_reg;
    logic [CNT_W-1:0] depth_reg [WARPS];

    logic       b_valid_reg;
    sbr_item_t  b_item_reg;
    logic [CNT_W-1:0] b_depth_reg;
    logic       b_bank_reg;
    sbr_entry_t rd_even_reg;
    sbr_entry_t rd_odd_reg;
    logic       v_even_reg;
    logic       v_odd_reg;
    logic       fwd_even_reg;
    logic       fwd_odd_reg;
    sbr_entry_t fwd_even_data_reg;
    sbr_entry_t fwd_odd_data_reg;

    logic b_fire;
    logic ofull;
    logic [CNT_W-1:0] d_upd;
    logic [CNT_W-1:0] d_rd;
    logic [STACK_LOG2-1:0] top_slot;
    logic [ROW_W-1:0] rd_row;

    logic [CNT_W-1:0] ot_cnt;
    logic ft_en;
    logic ot_en;
    sbr_entry_t ft_e;
    sbr_entry_t ot_e;
    logic we_even;
    logic we_odd;
    logic [ROW_W-1:0] wa_even;
    logic [ROW_W-1:0] wa_odd;
    sbr_entry_t wd_even;
    sbr_entry_t wd_odd;

    sbr_entry_t top_even;
    sbr_entry_t top_odd;
    sbr_entry_t top;
    sbr_result_t res;

    sbr_result_t oq_reg [2];
    logic       owr_reg;
    logic       ord_reg;
    logic [1:0] ocnt_reg;
    logic       do_pop;

    assign ofull  = (ocnt_reg == 2'd2);
    assign b_fire = b_valid_reg && !ofull;
    assign q_pop  = q_valid && (!b_valid_reg || b_fire);

    always_comb
    begin
        d_upd = b_depth_reg;
        if (b_item_reg.ctrl.split)
        begin
            d_upd = b_depth_reg + CNT_W'(2);
        end
        else if (b_item_reg.ctrl.join_op)
        begin
            d_upd = b_depth_reg - CNT_W'(1);
        end

        d_rd = depth_reg[q_item.warp_id];
        if (b_fire && b_item_reg.warp_id == q_item.warp_id)
        begin
            d_rd = d_upd;
        end
        top_slot = STACK_LOG2'(d_rd - CNT_W'(1));
        rd_row   = {q_item.warp_id, top_slot[STACK_LOG2-1:1]};
    end

    // split writes
    always_comb
    begin
        ot_cnt = b_depth_reg + CNT_W'(1);
        ft_en  = b_fire && b_item_reg.ctrl.split && !b_depth_reg[CNT_W-1];
        ot_en  = b_fire && b_item_reg.ctrl.split && !ot_cnt[CNT_W-1];
        ft_e.ft   = 1'b1;
        ft_e.mask = b_item_reg.active;
        ft_e.pc   = '0;
        ot_e.ft   = 1'b0;
        ot_e.mask = b_item_reg.active & ~b_item_reg.pred;
        ot_e.pc   = b_item_reg.cur_pc;

        we_even = 1'b0;
        we_odd  = 1'b0;
        wa_even = {b_item_reg.warp_id, b_depth_reg[STACK_LOG2-1:1]};
        wa_odd  = wa_even;
        wd_even = ft_e;
        wd_odd  = ft_e;
        if (ft_en && !b_depth_reg[0])
        begin
            we_even = 1'b1;
        end
        if (ft_en && b_depth_reg[0])
        begin
            we_odd = 1'b1;
        end
        if (ot_en && !ot_cnt[0])
        begin
            we_even = 1'b1;
            wa_even = {b_item_reg.warp_id, ot_cnt[STACK_LOG2-1:1]};
            wd_even = ot_e;
        end
        if (ot_en && ot_cnt[0])
        begin
            we_odd = 1'b1;
            wa_odd = {b_item_reg.warp_id, ot_cnt[STACK_LOG2-1:1]};
            wd_odd = ot_e;
        end
    end

    always_ff @(posedge clk)
    begin
        if (we_even)
        begin
            mem_even[wa_even] <= wd_even;
        end
        if (q_pop)
        begin
            rd_even_reg <= mem_even[rd_row];
        end
    end

    always_ff @(posedge clk)
    begin
        if (we_odd)
        begin
            mem_odd[wa_odd] <= wd_odd;
        end
        if (q_pop)
        begin
            rd_odd_reg <= mem_odd[rd_row];
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            b_item_reg        <= q_item;
            b_depth_reg       <= d_rd;
            b_bank_reg        <= top_slot[0];
            fwd_even_data_reg <= wd_even;
            fwd_odd_data_reg  <= wd_odd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg  <= 1'b0;
            val_even_reg <= '0;
            val_odd_reg  <= '0;
            v_even_reg   <= 1'b0;
            v_odd_reg    <= 1'b0;
            fwd_even_reg <= 1'b0;
            fwd_odd_reg  <= 1'b0;
            for (int w = 0; w < WARPS; w++)
            begin
                depth_reg[w] <= '0;
            end
        end
        else
        begin
            if (q_pop)
            begin
                b_valid_reg <= 1'b1;
            end
            else if (b_fire)
            begin
                b_valid_reg <= 1'b0;
            end
            if (q_pop)
            begin
                v_even_reg   <= val_even_reg[rd_row];
                v_odd_reg    <= val_odd_reg[rd_row];
                fwd_even_reg <= we_even && (wa_even == rd_row);
                fwd_odd_reg  <= we_odd && (wa_odd == rd_row);
            end
            if (we_even)
            begin
                val_even_reg[wa_even] <= 1'b1;
            end
            if (we_odd)
            begin
                val_odd_reg[wa_odd] <= 1'b1;
            end
            if (b_fire)
            begin
                depth_reg[b_item_reg.warp_id] <= d_upd;
            end
        end
    end

    // execute
    always_comb
    begin
        top_even = fwd_even_reg ? fwd_even_data_reg : (v_even_reg ? rd_even_reg : '0);
        top_odd  = fwd_odd_reg ? fwd_odd_data_reg : (v_odd_reg ? rd_odd_reg : '0);
        top      = b_bank_reg ? top_odd : top_even;

        res.warp_id     = b_item_reg.warp_id;
        res.next_pc     = b_item_reg.cur_pc;
        res.next_active = b_item_reg.active;
        if (b_item_reg.taken)
        begin
            if (b_item_reg.ctrl.pc_dest)
            begin
                res.next_pc = b_item_reg.dest_val;
            end
            else if (b_item_reg.ctrl.pc_imm)
            begin
                res.next_pc = b_item_reg.imm_target;
            end
            else if (b_item_reg.ctrl.join_op && !top.ft)
            begin
                res.next_pc = top.pc;
            end

            if (b_item_reg.ctrl.mask_lanes)
            begin
                res.next_active = b_item_reg.lane_mask;
            end
            else if (b_item_reg.ctrl.mask_one)
            begin
                res.next_active = LANES'(1);
            end
            else if (b_item_reg.ctrl.split)
            begin
                res.next_active = b_item_reg.active & b_item_reg.pred;
            end
            else if (b_item_reg.ctrl.join_op)
            begin
                res.next_active = top.mask;
            end
        end
        res.wb_mask      = b_item_reg.wb_mask;
        res.wb_reg       = b_item_reg.wb_reg;
        res.wb_value     = b_item_reg.cur_pc;
        res.spawn        = b_item_reg.spawn;
        res.spawn_target = b_item_reg.spawn_target;
    end

    // result queue
    assign empty  = (ocnt_reg == 2'd0);
    assign result = oq_reg[ord_reg];
    assign do_pop = pop && !empty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            owr_reg  <= 1'b0;
            ord_reg  <= 1'b0;
            ocnt_reg <= 2'd0;
        end
        else
        begin
            if (b_fire && !do_pop)
            begin
                ocnt_reg <= ocnt_reg + 2'd1;
            end
            else if (!b_fire && do_pop)
            begin
                ocnt_reg <= ocnt_reg - 2'd1;
            end
            if (b_fire)
            begin
                owr_reg <= !owr_reg;
            end
            if (do_pop)
            begin
                ord_reg <= !ord_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (b_fire)
        begin
            oq_reg[owr_reg] <= res;
        end
    end

    a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_valid)
        else $error("queue popped while empty");

    a_ocnt: assert property (@(posedge clk) disable iff (!rst_n)
        ocnt_reg != 2'd3)
        else $error("result queue overrun");

    a_split_write: assert property (@(posedge clk) disable iff (!rst_n)
        (b_fire && b_item_reg.ctrl.split && !b_depth_reg[CNT_W-1]) |-> (we_even || we_odd))
        else $error("split lost its fallthrough entry");

    a_depth: assert property (@(posedge clk) disable iff (!rst_n)
        (b_fire && b_item_reg.ctrl.split) |=>
        depth_reg[$past(b_item_reg.warp_id)] == $past(d_upd))
        else $error("stack depth not updated on split");

endmodule

`default_nettype wire

@@ rtl/core/simt_branch_unit_reconvergence_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none

// SIMT branch unit with a per-warp reconvergence stack. One warp instruction
// per cycle can be pushed unless full; a front end picks the lowest active and
// predicated lane and classifies the opcode, a two-entry queue decouples it
// from the back end, which reads the top stack entry (registered read,
// forwarded from the previous transaction), resolves next pc / mask and updates
// the stack. Results appear in order through a two-entry output queue.
// Throughput is one transaction per cycle while it is not full, set by the
// single stack update per cycle in the back end. No clearing pass after reset.
module simt_branch_unit_reconvergence_unit
    import sbr_pkg::*;
(
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        push,
    output logic                             full,
    input  wire logic [WARP_W-1:0]           warp_id,
    input  wire logic [WORD_BITS-1:0]        cur_pc,
    input  wire logic [LANES-1:0]            active_mask,
    input  wire logic [LANES-1:0]            pred_mask,
    input  wire logic [5:0]                  opcode,
    input  wire logic signed [WORD_BITS-1:0] immediate,
    input  wire logic                        has_dest,
    input  wire logic [5:0]                  dest_reg,
    input  wire logic [63:0]                 src0_lanes,
    input  wire logic [63:0]                 src1_lanes,
    output logic                             empty,
    input  wire logic                        pop,
    output logic [WARP_W-1:0]                out_warp_id,
    output logic [WORD_BITS-1:0]             next_pc,
    output logic [LANES-1:0]                 next_active,
    output logic [LANES-1:0]                 wb_mask,
    output logic [5:0]                       wb_reg,
    output logic [WORD_BITS-1:0]             wb_value,
    output logic                             spawn,
    output logic [WORD_BITS-1:0]             spawn_target
);

    logic        q_valid;
    logic        q_pop;
    sbr_item_t   q_item;
    sbr_result_t result;

    sbr_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .warp_id     (warp_id),
        .cur_pc      (cur_pc),
        .active_mask (active_mask),
        .pred_mask   (pred_mask),
        .opcode      (opcode),
        .immediate   (immediate),
        .has_dest    (has_dest),
        .dest_reg    (dest_reg),
        .src0_lanes  (src0_lanes),
        .src1_lanes  (src1_lanes),
        .q_valid     (q_valid),
        .q_item      (q_item),
        .q_pop       (q_pop)
    );

    sbr_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .q_item  (q_item),
        .q_pop   (q_pop),
        .empty   (empty),
        .pop     (pop),
        .result  (result)
    );

    assign out_warp_id  = result.warp_id;
    assign next_pc      = result.next_pc;
    assign next_active  = result.next_active;
    assign wb_mask      = result.wb_mask;
    assign wb_reg       = result.wb_reg;
    assign wb_value     = result.wb_value;
    assign spawn        = result.spawn;
    assign spawn_target = result.spawn_target;

endmodule

`default_nettype wire
